[hw/rtl/recs_pkg.sv]
// Package for the reciprocating endpoint cycle sequencer: widths, opcodes,
// motion commands, run phases and configuration register indexes.
// Depends on nothing; used by reciprocating_endpoint_cycle_sequencer.
package recs_pkg;

    // Position and cycle counter widths
    localparam int POSITION_BITS = 32;
    localparam int COUNT_BITS    = 32;
    // Dwell length and cycle goal registers are fixed at 32 bits
    localparam int TICK_BITS     = 32;
    localparam int GOAL_BITS     = 32;
    // Config write data is as wide as the widest register
    localparam int CFG_DATA_BITS = (POSITION_BITS > 32) ? POSITION_BITS : 32;
    localparam int CFG_IDX_BITS  = 3;

    typedef logic signed [POSITION_BITS-1:0] pos_t;
    typedef logic [COUNT_BITS-1:0]           count_t;
    typedef logic [TICK_BITS-1:0]            tick_t;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_PAUSE = 2'd2,
        OP_STOP  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_MOVE  = 2'd1,
        CMD_DECEL = 2'd2,
        CMD_HOLD  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_RUN   = 2'd1,
        PH_PAUSE = 2'd2,
        PH_STOP  = 2'd3
    } phase_t;

    localparam logic [CFG_IDX_BITS-1:0] CFG_ENDPOINT_A  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ENDPOINT_B  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DWELL_TICKS = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CYCLE_GOAL  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LIVE_EN     = 3'd4;

    // One result beat
    typedef struct packed {
        cmd_t   motion_command;
        pos_t   target_position;
        phase_t run_status;
        count_t cycles_count;
        logic   in_dwell_flag;
        logic   rejected;
    } result_t;

endpackage

[hw/rtl/reciprocating_endpoint_cycle_sequencer.sv]
// Reciprocating endpoint cycle sequencer: top level with input register,
// single-pass step logic, state registers and result register.
// Depends on recs_pkg.
//
// Sequences an A/B endurance run. Every input beat (a 1 ms tick or a start,
// pause or stop command) produces exactly one result beat carrying the motion
// command for the motor, the target endpoint on a move, the run phase, the
// completed cycle count, the dwell flag and a reject flag. Throughput is one
// beat per clock while m_ready does not stall the result register: the input
// beat lands in an input register, the step logic (two position subtracts, an
// absolute-distance compare, the dwell down counter and the saturating cycle
// counter) is combinational from there, and the result lands in an output
// register. The output register and input register each keep accepting while
// downstream takes the previous beat; a stall on m_ready backs up through
// both. Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at
// the clock edge and must only be issued with no beat in flight; clearing
// live_enabled forces the run phase to idle. There is no reset sweep: the
// block takes beats right after aresetn is released.
module reciprocating_endpoint_cycle_sequencer (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Configuration write port
    input  logic                                 cfg_we,
    input  logic [recs_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [recs_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    // Input channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [1:0]                           s_operation,
    input  logic                                 s_motor_at_target,
    input  logic signed [recs_pkg::POSITION_BITS-1:0] s_motor_position,
    // Result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [1:0]                           m_motion_command,
    output logic signed [recs_pkg::POSITION_BITS-1:0] m_target_position,
    output logic [1:0]                           m_run_status,
    output logic [recs_pkg::COUNT_BITS-1:0]      m_cycles_count,
    output logic                                 m_in_dwell_flag,
    output logic                                 m_rejected
);
    import recs_pkg::*;

    localparam int DIST_BITS = POSITION_BITS + 1;

    // Configuration registers
    pos_t                endpoint_a_reg;
    pos_t                endpoint_b_reg;
    tick_t               dwell_ticks_reg;
    logic [GOAL_BITS-1:0] cycle_goal_reg;
    logic                live_enabled_reg;

    // Sequencer state
    phase_t run_phase_reg,   run_phase_next;
    logic   last_side_a_reg, last_side_a_next;
    count_t cycles_done_reg, cycles_done_next;
    logic   dwelling_reg,    dwelling_next;
    tick_t  dwell_left_reg,  dwell_left_next;

    // Input register
    logic   in_valid_reg;
    op_t    in_op_reg;
    logic   in_at_target_reg;
    pos_t   in_pos_reg;

    // Result register
    logic    out_valid_reg;
    result_t out_reg, out_next;

    logic advance;   // result register can take a new beat
    logic fire;      // step runs on the beat in the input register

    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    // ---------------- input register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg        <= op_t'(s_operation);
            in_at_target_reg <= s_motor_at_target;
            in_pos_reg       <= s_motor_position;
        end
    end

    // ---------------- step logic ----------------
    logic signed [DIST_BITS-1:0] diff_a, diff_b;
    logic [DIST_BITS-1:0]        dist_a, dist_b;
    logic                        nearer_a;

    // Distance of the motor to each endpoint, one bit wider so it cannot wrap
    assign diff_a   = DIST_BITS'(in_pos_reg) - DIST_BITS'(endpoint_a_reg);
    assign diff_b   = DIST_BITS'(in_pos_reg) - DIST_BITS'(endpoint_b_reg);
    assign dist_a   = diff_a[DIST_BITS-1] ? DIST_BITS'(-diff_a) : DIST_BITS'(diff_a);
    assign dist_b   = diff_b[DIST_BITS-1] ? DIST_BITS'(-diff_b) : DIST_BITS'(diff_b);
    assign nearer_a = dist_a < dist_b;   // a tie counts as side B

    always_comb begin
        cmd_t   cmd;
        pos_t   target;
        logic   rej;
        tick_t  dwell_dec;
        count_t cnt;
        logic   side_a;

        cmd              = CMD_NONE;
        target           = '0;
        rej              = 1'b0;
        run_phase_next   = run_phase_reg;
        last_side_a_next = last_side_a_reg;
        cycles_done_next = cycles_done_reg;
        dwelling_next    = dwelling_reg;
        dwell_left_next  = dwell_left_reg;
        dwell_dec        = (dwell_left_reg != '0) ? dwell_left_reg - 1'b1 : '0;
        cnt              = cycles_done_reg;
        side_a           = last_side_a_reg;

        unique case (in_op_reg)
            OP_START: begin
                if (!live_enabled_reg) begin
                    rej = 1'b1;
                end else begin
                    cycles_done_next = '0;
                    last_side_a_next = 1'b1;
                    // a start while already running keeps the move and dwell going
                    if (run_phase_reg != PH_RUN) begin
                        dwelling_next = 1'b0;
                        cmd           = CMD_MOVE;
                        target        = endpoint_b_reg;
                    end
                    run_phase_next = PH_RUN;
                end
            end
            OP_PAUSE: begin
                if (run_phase_reg == PH_RUN) begin
                    run_phase_next = PH_PAUSE;
                end else begin
                    rej = 1'b1;
                end
            end
            OP_STOP: begin
                cmd            = CMD_DECEL;
                run_phase_next = PH_STOP;
            end
            OP_TICK: begin
                if (live_enabled_reg) begin
                    unique case (run_phase_reg)
                        PH_RUN: begin
                            if (dwelling_reg) begin
                                dwell_left_next = dwell_dec;
                                if (dwell_dec == '0) begin
                                    dwelling_next = 1'b0;
                                    cmd           = CMD_MOVE;
                                    target = last_side_a_reg ? endpoint_b_reg : endpoint_a_reg;
                                end
                            end else if (in_at_target_reg) begin
                                if (nearer_a) begin
                                    // arriving at A from B closes one cycle
                                    if (!last_side_a_reg && (cycles_done_reg != '1)) begin
                                        cnt = cycles_done_reg + 1'b1;
                                    end
                                    side_a = 1'b1;
                                end else begin
                                    side_a = 1'b0;
                                end
                                last_side_a_next = side_a;
                                cycles_done_next = cnt;
                                if (GOAL_BITS'(cnt) >= cycle_goal_reg) begin
                                    run_phase_next = PH_IDLE;
                                    cmd            = CMD_HOLD;
                                end else begin
                                    dwelling_next   = 1'b1;
                                    dwell_left_next = dwell_ticks_reg;
                                end
                            end
                        end
                        PH_PAUSE: begin
                            cmd = CMD_DECEL;
                        end
                        PH_STOP: begin
                            cmd            = CMD_HOLD;
                            dwelling_next  = 1'b0;
                            run_phase_next = PH_IDLE;
                        end
                        PH_IDLE: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase

        out_next.motion_command  = cmd;
        out_next.target_position = (cmd == CMD_MOVE) ? target : '0;
        out_next.run_status      = run_phase_next;
        out_next.cycles_count    = cycles_done_next;
        out_next.in_dwell_flag   = dwelling_next;
        out_next.rejected        = rej;
    end

    // ---------------- config and state registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            endpoint_a_reg   <= '0;
            endpoint_b_reg   <= POSITION_BITS'(-6400);
            dwell_ticks_reg  <= TICK_BITS'(5000);
            cycle_goal_reg   <= GOAL_BITS'(10);
            live_enabled_reg <= 1'b0;
            run_phase_reg    <= PH_IDLE;
            last_side_a_reg  <= 1'b1;
            cycles_done_reg  <= '0;
            dwelling_reg     <= 1'b0;
            dwell_left_reg   <= '0;
        end else begin
            if (fire) begin
                run_phase_reg   <= run_phase_next;
                last_side_a_reg <= last_side_a_next;
                cycles_done_reg <= cycles_done_next;
                dwelling_reg    <= dwelling_next;
                dwell_left_reg  <= dwell_left_next;
            end
            // config writes must only arrive with the pipe empty; the block does not enforce it
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_ENDPOINT_A:  endpoint_a_reg  <= cfg_wdata[POSITION_BITS-1:0];
                    CFG_ENDPOINT_B:  endpoint_b_reg  <= cfg_wdata[POSITION_BITS-1:0];
                    CFG_DWELL_TICKS: dwell_ticks_reg <= cfg_wdata[TICK_BITS-1:0];
                    CFG_CYCLE_GOAL:  cycle_goal_reg  <= cfg_wdata[GOAL_BITS-1:0];
                    CFG_LIVE_EN: begin
                        live_enabled_reg <= cfg_wdata[0];
                        if (!cfg_wdata[0]) begin
                            run_phase_reg <= PH_IDLE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= out_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_motion_command  = out_reg.motion_command;
    assign m_target_position = out_reg.target_position;
    assign m_run_status      = out_reg.run_status;
    assign m_cycles_count    = out_reg.cycles_count;
    assign m_in_dwell_flag   = out_reg.in_dwell_flag;
    assign m_rejected        = out_reg.rejected;

`ifndef SYNTHESIS
    // target is only driven on a move
    a_target_only_on_move: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_motion_command != CMD_MOVE) |-> m_target_position == '0)
        else $error("target position set without a move command");

    // a refused command never moves the motor
    a_reject_no_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rejected |-> m_motion_command == CMD_NONE)
        else $error("rejected beat carries a motion command");

    // the cycle count only changes when a beat is processed
    a_count_only_on_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(cycles_done_reg))
        else $error("cycle count changed without a step");

    // entering the running phase takes a start command
    a_run_needs_start: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (run_phase_next == PH_RUN) && (run_phase_reg != PH_RUN)
            |-> in_op_reg == OP_START)
        else $error("run phase entered without start");
`endif

endmodule
